// File: hw/rtl/stq_pkg.sv
// Package for the sorted timer queue: shared constants, controller states and the
// command and status structs between the controller and the datapath.
// No dependencies.
package stq_pkg;

   localparam int unsigned ID_W      = 4;
   localparam int unsigned DELAY_W   = 16;
   localparam int unsigned DL_W      = 17;
   localparam int unsigned TOTAL_W   = 32;
   localparam int unsigned MASK_W    = 16;

   localparam logic [DL_W-1:0]    DEADLINE_MAX      = 17'h1FFFF;
   localparam logic [DELAY_W-1:0] DELAY_LIMIT_RESET = 16'd10000;

   // Request kinds carried on the request side-band.
   localparam logic FUNC_TICK   = 1'b0;
   localparam logic FUNC_CREATE = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_UPDATE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;      // capture the request payload
      logic eval;      // check a create or advance time for a tick
      logic update;    // change the sorted list
      logic emit;      // load the response register
      logic cfg_write; // write delay_limit
   } cmd_type;

   typedef struct packed {
      logic change;    // the evaluated item alters the list
   } sts_type;

endpackage

// File: hw/rtl/stq_ctrl.sv
// Controller of the sorted timer queue: sequences one item at a time, owns the request
// and response handshakes and passes register writes on to the datapath. Uses stq_pkg.
module stq_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  logic               csr_valid,
   output stq_pkg::cmd_type   cmd,
   input  stq_pkg::sts_type   sts
);

   stq_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= stq_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      req_tready    = 1'b0;
      cmd.cfg_write = csr_valid;
      unique case (state_ff)
         stq_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = stq_pkg::ST_EVAL;
            end
         end
         stq_pkg::ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = stq_pkg::ST_UPDATE;
         end
         stq_pkg::ST_UPDATE: begin
            cmd.update = sts.change;
            state_in   = stq_pkg::ST_EMIT;
         end
         stq_pkg::ST_EMIT: begin
            // Wait until the response register is free or being emptied.
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.emit = 1'b1;
               state_in = stq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = stq_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   // A response is never overwritten before it has been transferred.
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_tready))
      else $error("response register overwritten");

   // An accepted request is evaluated in the following cycle.
   a_load_eval: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> cmd.eval)
      else $error("request not evaluated after transfer");

   // The list only changes in the cycle straight after evaluation.
   a_update_order: assert property (@(posedge clock) disable iff (reset)
      cmd.update |-> $past(cmd.eval))
      else $error("update issued without evaluation");

endmodule

// File: hw/rtl/stq_datapath.sv
// Datapath of the sorted timer queue: the row of deadline/owner cells, counters,
// pending mask, delay limit and response payload register. Uses stq_pkg.
module stq_datapath #(
   parameter int unsigned NUM_TIMERS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  stq_pkg::cmd_type              cmd,
   output stq_pkg::sts_type              sts,
   input  logic                          req_func,
   input  logic [stq_pkg::ID_W-1:0]      req_timer_id,
   input  logic [stq_pkg::DELAY_W-1:0]   req_delay,
   input  logic [stq_pkg::DELAY_W-1:0]   csr_wdata,
   output logic                          rsp_fired,
   output logic [stq_pkg::ID_W-1:0]      rsp_fired_id,
   output logic                          rsp_accepted,
   output logic [stq_pkg::TOTAL_W-1:0]   rsp_tick_count
);

   localparam int unsigned CW = $clog2(NUM_TIMERS + 1);
   localparam int unsigned DW = stq_pkg::DL_W;

   // Captured request.
   logic                        func_ff;
   logic [stq_pkg::ID_W-1:0]    id_ff;
   logic [stq_pkg::DELAY_W-1:0] delay_ff;

   // Evaluation results.
   logic [DW-1:0]               dl_ff, dl_in;
   logic                        ok_ff, ok_in;
   logic                        fire_ff, fire_in;
   logic [stq_pkg::ID_W-1:0]    fid_ff;

   // Queue state.
   logic [DW-1:0]               deadline_ff [NUM_TIMERS];
   logic [stq_pkg::ID_W-1:0]    owner_ff    [NUM_TIMERS];
   logic [CW-1:0]               count_ff, count_in;
   logic [stq_pkg::MASK_W-1:0]  mask_ff, mask_in;
   logic [DW-1:0]               elapsed_ff, elapsed_in, elapsed_step;
   logic [stq_pkg::TOTAL_W-1:0] total_ff, total_in;
   logic [stq_pkg::DELAY_W-1:0] limit_ff;

   logic [DW:0]                 dl_sum;
   logic [NUM_TIMERS-1:0]       le_vec;
   logic [NUM_TIMERS-1:0]       prev_le;
   logic                        do_insert, do_remove;

   assign do_insert = cmd.update && (func_ff == stq_pkg::FUNC_CREATE);
   assign do_remove = cmd.update && (func_ff == stq_pkg::FUNC_TICK);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff  <= req_func;
         id_ff    <= req_timer_id;
         delay_ff <= req_delay;
      end
      if (cmd.eval) begin
         dl_ff  <= dl_in;
         fid_ff <= owner_ff[0];
      end
   end

   // Deadline of a create, saturated at the largest deadline.
   always_comb begin
      dl_sum = {1'b0, elapsed_ff} + (DW + 1)'(delay_ff);
      if (dl_sum > (DW + 1)'(stq_pkg::DEADLINE_MAX)) begin
         dl_in = stq_pkg::DEADLINE_MAX;
      end else begin
         dl_in = dl_sum[DW-1:0];
      end
   end

   assign elapsed_step = (elapsed_ff < stq_pkg::DEADLINE_MAX) ? elapsed_ff + DW'(1) : elapsed_ff;

   always_comb begin
      ok_in      = ok_ff;
      fire_in    = fire_ff;
      elapsed_in = elapsed_ff;
      total_in   = total_ff;
      count_in   = count_ff;
      mask_in    = mask_ff;
      if (cmd.eval) begin
         if (func_ff == stq_pkg::FUNC_CREATE) begin
            ok_in   = (delay_ff <= limit_ff) && (count_ff != CW'(NUM_TIMERS))
                      && !mask_ff[id_ff];
            fire_in = 1'b0;
         end else begin
            ok_in    = 1'b0;
            total_in = total_ff + 32'd1;
            if (count_ff != '0) begin
               elapsed_in = elapsed_step;
               fire_in    = (elapsed_step >= deadline_ff[0]);
            end else begin
               fire_in = 1'b0;
            end
         end
      end
      if (do_insert) begin
         count_in = count_ff + CW'(1);
         mask_in  = mask_ff | (stq_pkg::MASK_W'(1) << id_ff);
      end
      if (do_remove) begin
         count_in   = count_ff - CW'(1);
         mask_in    = mask_ff & ~(stq_pkg::MASK_W'(1) << fid_ff);
         elapsed_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ok_ff      <= 1'b0;
         fire_ff    <= 1'b0;
         elapsed_ff <= '0;
         total_ff   <= '0;
         count_ff   <= '0;
         mask_ff    <= '0;
         limit_ff   <= stq_pkg::DELAY_LIMIT_RESET;
      end else begin
         ok_ff      <= ok_in;
         fire_ff    <= fire_in;
         elapsed_ff <= elapsed_in;
         total_ff   <= total_in;
         count_ff   <= count_in;
         mask_ff    <= mask_in;
         if (cmd.cfg_write) begin
            limit_ff <= csr_wdata;
         end
      end
   end

   assign sts.change = (func_ff == stq_pkg::FUNC_CREATE) ? ok_ff : fire_ff;

   // Cells at or before the insertion point keep their place; the sorted order makes
   // le_vec a run of ones followed by zeros.
   generate
      for (genvar k = 0; k < NUM_TIMERS; k++) begin : g_cell
         // What the cell takes when an insert moves the tail up by one.
         logic [DW-1:0]            up_dl;
         logic [stq_pkg::ID_W-1:0] up_owner;

         assign le_vec[k] = (CW'(k) < count_ff) && (deadline_ff[k] <= dl_ff);
         if (k == 0) begin : g_first
            assign prev_le[k] = 1'b1;
            assign up_dl      = dl_ff;
            assign up_owner   = id_ff;
         end else begin : g_rest
            assign prev_le[k] = le_vec[k-1];
            assign up_dl      = prev_le[k] ? dl_ff : deadline_ff[k-1];
            assign up_owner   = prev_le[k] ? id_ff : owner_ff[k-1];
         end

         if (k < NUM_TIMERS - 1) begin : g_rebase
            logic [DW-1:0] next_dl, rebased;
            assign next_dl = deadline_ff[k+1];
            assign rebased = (next_dl > elapsed_ff) ? next_dl - elapsed_ff : '0;
            always_ff @(posedge clock) begin
               if (do_insert && !le_vec[k]) begin
                  deadline_ff[k] <= up_dl;
                  owner_ff[k]    <= up_owner;
               end else if (do_remove) begin
                  deadline_ff[k] <= rebased;
                  owner_ff[k]    <= owner_ff[k+1];
               end
            end
         end else begin : g_last
            always_ff @(posedge clock) begin
               if (do_insert && !le_vec[k]) begin
                  deadline_ff[k] <= up_dl;
                  owner_ff[k]    <= up_owner;
               end
            end
         end
      end
   endgenerate

   // Response payload register.
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_fired      <= fire_ff && (func_ff == stq_pkg::FUNC_TICK);
         rsp_fired_id   <= (fire_ff && (func_ff == stq_pkg::FUNC_TICK)) ? fid_ff : '0;
         rsp_accepted   <= ok_ff && (func_ff == stq_pkg::FUNC_CREATE);
         rsp_tick_count <= total_ff;
      end
   end

   // The pending mask and the fill count describe the same set of timers.
   a_mask_count: assert property (@(posedge clock) disable iff (reset)
      $countones(mask_ff) == int'(count_ff))
      else $error("pending mask disagrees with fill count");

   // The list never holds more entries than it has cells.
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(NUM_TIMERS))
      else $error("fill count beyond capacity");

   // The list only changes for an accepted create or a firing tick.
   a_update_cause: assert property (@(posedge clock) disable iff (reset)
      cmd.update |-> ((func_ff == stq_pkg::FUNC_CREATE) ? ok_ff : (fire_ff && count_ff != '0)))
      else $error("list changed without cause");

endmodule

// File: hw/rtl/sorted_timer_queue.sv
// Sorted one-shot timer queue: ticks and create requests in, one response each out.
// The response becomes valid after the evaluate, update and emit steps that follow the
// request transfer; the emit step waits longer only while the response register still
// waits on rsp_tready.
// A new request is taken only after the previous item has left the controller's four-step sequence.
// Reset (synchronous) empties the queue, clears the counters and sets delay_limit to
// 10000; the cell row needs no clearing pass because the fill count guards it.
module sorted_timer_queue #(
   parameter int unsigned NUM_TIMERS = 16
) (
   input  logic        clock,
   input  logic        reset,

   // Request channel. tuser: func (0 = tick, 1 = create).
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [3:0] timer_id, [19:4] delay, [23:20] zero
   input  logic        req_tuser,   // [0] func

   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [3:0] fired_id, [35:4] tick_count, [39:36] zero
   output logic [1:0]  rsp_tuser,   // [0] fired, [1] accepted

   // delay_limit write channel.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_wdata
);

   stq_pkg::cmd_type cmd;
   stq_pkg::sts_type sts;

   logic                          rsp_fired;
   logic [stq_pkg::ID_W-1:0]      rsp_fired_id;
   logic                          rsp_accepted;
   logic [stq_pkg::TOTAL_W-1:0]   rsp_tick_count;

   // Register writes are always taken; the user must have them arrive only while the queue is idle (unenforced).
   assign csr_ready = 1'b1;

   // The controller sequences each item and owns the request and response handshakes.
   stq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .cmd        (cmd),
      .sts        (sts)
   );

   // The datapath holds the sorted cells: an insert shifts the later cells up by one,
   // and a firing tick shifts every cell but the last down and rebases it against
   // the elapsed count in the same cycle.
   stq_datapath #(
      .NUM_TIMERS (NUM_TIMERS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_func       (req_tuser),
      .req_timer_id   (req_tdata[3:0]),
      .req_delay      (req_tdata[19:4]),
      .csr_wdata      (csr_wdata),
      .rsp_fired      (rsp_fired),
      .rsp_fired_id   (rsp_fired_id),
      .rsp_accepted   (rsp_accepted),
      .rsp_tick_count (rsp_tick_count)
   );

   // Pack the response fields, lowest field first.
   assign rsp_tdata = {4'b0000, rsp_tick_count, rsp_fired_id};
   assign rsp_tuser = {rsp_accepted, rsp_fired};

endmodule
